>>> rtl/spqtc_pkg.sv
// Shared types and constants for the sorted priority queue with type counts.
`timescale 1ns / 1ps
`default_nettype none

package spqtc_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 64;

  // Width of the reported occupancy and count fields.
  localparam int unsigned CNT_OUT_W = 7;

  // Type bytes that are tallied.
  localparam logic [7:0] TYPE_P = 8'h70;
  localparam logic [7:0] TYPE_B = 8'h62;
  localparam logic [7:0] TYPE_G = 8'h67;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [7:0]         kind;
    logic [63:0]        code;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic   ins_go;
    logic   rem_go;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/spqtc_in_if.sv
// Input channel: insert/remove request words.
`timescale 1ns / 1ps
`default_nettype none

interface spqtc_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] new_value;
  logic [7:0]         new_type;
  logic [63:0]        new_code;

  modport source (output valid, output action, output new_value, output new_type,
                  output new_code, input ready);
  modport sink (input valid, input action, input new_value, input new_type,
                input new_code, output ready);
endinterface

`default_nettype wire

>>> rtl/spqtc_out_if.sv
// Result channel: removed entry, overflow flag, occupancy and type counts.
`timescale 1ns / 1ps
`default_nettype none

interface spqtc_out_if;
  logic               valid;
  logic               ready;
  logic               removed_valid;
  logic signed [31:0] removed_value;
  logic [7:0]         removed_type;
  logic [63:0]        removed_code;
  logic               overflow;
  logic [6:0]         occupancy;
  logic [6:0]         count_p;
  logic [6:0]         count_b;
  logic [6:0]         count_g;

  modport source (output valid, output removed_valid, output removed_value,
                  output removed_type, output removed_code, output overflow,
                  output occupancy, output count_p, output count_b, output count_g,
                  input ready);
  modport sink (input valid, input removed_valid, input removed_value,
                input removed_type, input removed_code, input overflow,
                input occupancy, input count_p, input count_b, input count_g,
                output ready);
endinterface

`default_nettype wire

>>> rtl/spqtc_cell.sv
// One slot of the sorted chain; slot 0 holds the largest (newest among equals) entry.
`timescale 1ns / 1ps
`default_nettype none

module spqtc_cell #(
  parameter int unsigned DEPTH = spqtc_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int unsigned IDX   = 0,
  localparam int unsigned FW   = $clog2(DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire spqtc_pkg::cell_ctl_t ctl,
  input  wire logic [FW-1:0]       fill,
  input  wire logic                prev_gt,    // neighbor toward slot 0 holds a larger value
  input  wire spqtc_pkg::entry_t   prev_entry,
  input  wire spqtc_pkg::entry_t   next_entry,
  output logic                     gt,
  output spqtc_pkg::entry_t        entry
);

  spqtc_pkg::entry_t entry_r;
  spqtc_pkg::entry_t entry_nxt;
  logic              occ;

  assign occ   = fill > FW'(IDX);
  assign gt    = occ && (entry_r.value > ctl.new_entry.value);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.rem_go) begin
      entry_nxt = next_entry;
    end else if (ctl.ins_go) begin
      if (gt) begin
        entry_nxt = entry_r;
      end else if (prev_gt) begin
        entry_nxt = ctl.new_entry;
      end else begin
        entry_nxt = prev_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/sorted_priority_queue_type_counts.sv
// Bounded sorted priority queue with per-type live counts (top level).
//
// Usage:
//   in_chan  (valid/ready): action 0 inserts {new_value, new_type, new_code},
//            action 1 removes the entry of largest value, newest first on ties.
//   out_chan (valid/ready): one result word per request: the removed entry
//            (removed_valid=0 and zero fields on insert or empty remove), the
//            overflow flag for an insert into a full queue, and occupancy and
//            counts of types 'p', 'b', 'g' after the request.
// Output: the result word is registered when the request is taken.
// Throughput: one request per cycle; every slot cell compares against the new
//   value and shifts with its neighbor in the same cycle.
// Stall: a held result blocks a new request only while out_chan is not ready;
//   the queue state does not move while stalled.
// Reset: synchronous, active low; empties the queue, clears counts and the
//   output valid. Slot contents are not cleared; slots beyond the fill level
//   are never read.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_type_counts #(
  parameter int unsigned QUEUE_DEPTH = spqtc_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  spqtc_in_if.sink  in_chan,
  spqtc_out_if.source out_chan
);

  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = (FW > spqtc_pkg::CNT_OUT_W) ? FW : spqtc_pkg::CNT_OUT_W;

  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] tally_p_r, tally_p_nxt;
  logic [FW-1:0] tally_b_r, tally_b_nxt;
  logic [FW-1:0] tally_g_r, tally_g_nxt;

  logic               out_valid_r;
  logic               rem_valid_r, rem_valid_nxt;
  spqtc_pkg::entry_t  rem_entry_r, rem_entry_nxt;
  logic               ovf_r, ovf_nxt;

  logic              accept;
  logic              full;
  logic              empty;
  spqtc_pkg::cell_ctl_t ctl;

  logic              gt_chain [QUEUE_DEPTH+1];
  spqtc_pkg::entry_t ent_chain [QUEUE_DEPTH+1];
  spqtc_pkg::entry_t cell_out  [QUEUE_DEPTH];

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign full          = fill_r == FW'(QUEUE_DEPTH);
  assign empty         = fill_r == '0;

  always_comb begin
    ctl.new_entry.value = in_chan.new_value;
    ctl.new_entry.kind  = in_chan.new_type;
    ctl.new_entry.code  = in_chan.new_code;
    ctl.ins_go = accept && (in_chan.action == spqtc_pkg::ACT_INSERT) && !full;
    ctl.rem_go = accept && (in_chan.action == spqtc_pkg::ACT_REMOVE) && !empty;
  end

  // Slot 0 sees a virtual larger neighbor so an insert that beats everything lands there.
  assign gt_chain[0]  = 1'b1;
  assign ent_chain[0] = ctl.new_entry;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spqtc_cell #(
      .DEPTH(QUEUE_DEPTH),
      .IDX  (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .fill      (fill_r),
      .prev_gt   (gt_chain[i]),
      .prev_entry(ent_chain[i]),
      .next_entry((i == QUEUE_DEPTH - 1) ? cell_out[i] : cell_out[(i + 1) % QUEUE_DEPTH]),
      .gt        (gt_chain[i+1]),
      .entry     (cell_out[i])
    );
    assign ent_chain[i+1] = cell_out[i];
  end

  always_comb begin
    fill_nxt      = fill_r;
    tally_p_nxt   = tally_p_r;
    tally_b_nxt   = tally_b_r;
    tally_g_nxt   = tally_g_r;
    rem_valid_nxt = 1'b0;
    rem_entry_nxt = '0;
    ovf_nxt       = 1'b0;
    if (ctl.ins_go) begin
      fill_nxt = fill_r + FW'(1);
      if (in_chan.new_type == spqtc_pkg::TYPE_P) tally_p_nxt = tally_p_r + FW'(1);
      if (in_chan.new_type == spqtc_pkg::TYPE_B) tally_b_nxt = tally_b_r + FW'(1);
      if (in_chan.new_type == spqtc_pkg::TYPE_G) tally_g_nxt = tally_g_r + FW'(1);
    end else if (ctl.rem_go) begin
      fill_nxt      = fill_r - FW'(1);
      rem_valid_nxt = 1'b1;
      rem_entry_nxt = cell_out[0];
      if (cell_out[0].kind == spqtc_pkg::TYPE_P && tally_p_r != '0)
        tally_p_nxt = tally_p_r - FW'(1);
      if (cell_out[0].kind == spqtc_pkg::TYPE_B && tally_b_r != '0)
        tally_b_nxt = tally_b_r - FW'(1);
      if (cell_out[0].kind == spqtc_pkg::TYPE_G && tally_g_r != '0)
        tally_g_nxt = tally_g_r - FW'(1);
    end else if (accept && in_chan.action == spqtc_pkg::ACT_INSERT) begin
      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      tally_p_r   <= '0;
      tally_b_r   <= '0;
      tally_g_r   <= '0;
      out_valid_r <= 1'b0;
      rem_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      if (accept) begin
        fill_r      <= fill_nxt;
        tally_p_r   <= tally_p_nxt;
        tally_b_r   <= tally_b_nxt;
        tally_g_r   <= tally_g_nxt;
        rem_valid_r <= rem_valid_nxt;
        ovf_r       <= ovf_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) rem_entry_r <= rem_entry_nxt;
  end

  logic [EW-1:0] occ_ext, cp_ext, cb_ext, cg_ext;
  assign occ_ext = EW'(fill_r);
  assign cp_ext  = EW'(tally_p_r);
  assign cb_ext  = EW'(tally_b_r);
  assign cg_ext  = EW'(tally_g_r);

  assign out_chan.valid         = out_valid_r;
  assign out_chan.removed_valid = rem_valid_r;
  assign out_chan.removed_value = rem_entry_r.value;
  assign out_chan.removed_type  = rem_entry_r.kind;
  assign out_chan.removed_code  = rem_entry_r.code;
  assign out_chan.overflow      = ovf_r;
  assign out_chan.occupancy     = occ_ext[spqtc_pkg::CNT_OUT_W-1:0];
  assign out_chan.count_p       = cp_ext[spqtc_pkg::CNT_OUT_W-1:0];
  assign out_chan.count_b       = cb_ext[spqtc_pkg::CNT_OUT_W-1:0];
  assign out_chan.count_g       = cg_ext[spqtc_pkg::CNT_OUT_W-1:0];

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(QUEUE_DEPTH))
    else $error("fill level above queue depth");

  a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.action == spqtc_pkg::ACT_REMOVE && empty |=> !out_chan.removed_valid)
    else $error("remove from empty queue returned an entry");

  a_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(ovf_r && rem_valid_r))
    else $error("overflow and removed entry in one word");

  a_tally_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (EW + 2)'(tally_p_r) + (EW + 2)'(tally_b_r) + (EW + 2)'(tally_g_r) <= (EW + 2)'(fill_r))
    else $error("type counts exceed occupancy");

endmodule

`default_nettype wire

>>> tb/sorted_priority_queue_type_counts_tb.sv
// Self-checking bench for the sorted priority queue with per-type live counts.
`timescale 1ns / 1ps

module sorted_priority_queue_type_counts_tb;

  localparam int QUEUE_DEPTH   = spqtc_pkg::DEFAULT_QUEUE_DEPTH;
  localparam int TAIL_QUIET    = 60;    // last words run with no idling
  localparam int LONG_HOLD_AT  = 150;   // results seen before the long sink stall
  localparam int LONG_HOLD_LEN = 120;
  localparam int STALL_LIMIT   = 1000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    bit                 drain;  // marker: hold off until all results are back
    spqtc_pkg::action_t act;
    logic signed [31:0] value;
    logic [7:0]         kind;
    logic [63:0]        code;
  } request_t;

  typedef struct packed {
    logic               removed_valid;
    logic signed [31:0] removed_value;
    logic [7:0]         removed_type;
    logic [63:0]        removed_code;
    logic               overflow;
    logic [6:0]         occupancy;
    logic [6:0]         count_p;
    logic [6:0]         count_b;
    logic [6:0]         count_g;
  } result_t;

  typedef enum int {SEG_MIXED, SEG_FILL, SEG_MOSTLY_IN, SEG_DRAIN} seg_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  spqtc_in_if  in_chan ();
  spqtc_out_if out_chan ();

  sorted_priority_queue_type_counts i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t offered = '{drain: 1'b0, act: spqtc_pkg::ACT_INSERT, value: '0, kind: '0,
                        code: '0};
  logic     drv_valid = 1'b0;
  logic     rcv_ready = 1'b0;
  logic     in_fire = 1'b0;

  assign in_chan.valid     = drv_valid;
  assign in_chan.action    = offered.act;
  assign in_chan.new_value = offered.value;
  assign in_chan.new_type  = offered.kind;
  assign in_chan.new_code  = offered.code;
  assign out_chan.ready    = rcv_ready;

  request_t stim_q[$];
  result_t  result_q[$];
  int       items_total = 0;
  int       items_taken = 0;
  int       results_seen = 0;
  int       quiet_from = 0;
  int       fail_count = 0;
  int       gen_fill = 0;

  // Shadow copy of the queue contents and tallies
  logic signed [31:0] q_value [QUEUE_DEPTH];
  logic [7:0]         q_kind  [QUEUE_DEPTH];
  logic [63:0]        q_code  [QUEUE_DEPTH];
  int                 q_fill = 0;
  int                 tally_p = 0;
  int                 tally_b = 0;
  int                 tally_g = 0;

  function automatic void tally_adjust(logic [7:0] kind, bit up);
    if (kind == spqtc_pkg::TYPE_P)
      tally_p = up ? tally_p + 1 : (tally_p > 0 ? tally_p - 1 : 0);
    else if (kind == spqtc_pkg::TYPE_B)
      tally_b = up ? tally_b + 1 : (tally_b > 0 ? tally_b - 1 : 0);
    else if (kind == spqtc_pkg::TYPE_G)
      tally_g = up ? tally_g + 1 : (tally_g > 0 ? tally_g - 1 : 0);
  endfunction

  function automatic result_t predict_queue_step(request_t r);
    result_t res;
    int      pos;
    res = '0;
    if (r.act == spqtc_pkg::ACT_INSERT) begin
      if (q_fill >= QUEUE_DEPTH) begin
        res.overflow = 1'b1;
      end else begin
        // new entry lands after every entry of equal or smaller value
        pos = 0;
        while (pos < q_fill && q_value[pos] <= r.value) pos++;
        for (int i = q_fill; i > pos; i--) begin
          q_value[i] = q_value[i-1];
          q_kind[i]  = q_kind[i-1];
          q_code[i]  = q_code[i-1];
        end
        q_value[pos] = r.value;
        q_kind[pos]  = r.kind;
        q_code[pos]  = r.code;
        q_fill++;
        tally_adjust(r.kind, 1'b1);
      end
    end else if (q_fill > 0) begin
      q_fill--;
      res.removed_valid = 1'b1;
      res.removed_value = q_value[q_fill];
      res.removed_type  = q_kind[q_fill];
      res.removed_code  = q_code[q_fill];
      tally_adjust(q_kind[q_fill], 1'b0);
    end
    res.occupancy = 7'(q_fill);
    res.count_p   = 7'(tally_p);
    res.count_b   = 7'(tally_b);
    res.count_g   = 7'(tally_g);
    return res;
  endfunction

  function automatic void add_insert(logic signed [31:0] value, logic [7:0] kind,
                                     logic [63:0] code);
    stim_q.push_back('{drain: 1'b0, act: spqtc_pkg::ACT_INSERT, value: value, kind: kind,
                       code: code});
    items_total++;
    if (gen_fill < QUEUE_DEPTH) gen_fill++;
  endfunction

  function automatic void add_remove();
    request_t r;
    // insert-only fields carry noise on removes
    r = '{drain: 1'b0, act: spqtc_pkg::ACT_REMOVE, value: $urandom, kind: 8'($urandom),
          code: {$urandom, $urandom}};
    stim_q.push_back(r);
    items_total++;
    if (gen_fill > 0) gen_fill--;
  endfunction

  function automatic void add_drain_marker();
    stim_q.push_back('{drain: 1'b1, act: spqtc_pkg::ACT_INSERT, value: '0, kind: '0,
                       code: '0});
  endfunction

  function automatic logic signed [31:0] pick_value();
    int sel = $urandom_range(0, 7);
    case (sel)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return ($signed(32'($urandom_range(0, 6))) - 3) <<< 8;  // forces ties
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_kind();
    case ($urandom_range(0, 4))
      0:       return spqtc_pkg::TYPE_P;
      1:       return spqtc_pkg::TYPE_B;
      2:       return spqtc_pkg::TYPE_G;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_random_insert();
    add_insert(pick_value(), pick_kind(), {$urandom, $urandom});
  endfunction

  // Stimulus, reset and end of run
  initial begin
    seg_mode_t mode;
    int        seg_idx;
    int        pct;

    // directed: empty remove, extremes, ties, untracked types
    add_remove();
    add_insert(32'h7FFF_FFFF, spqtc_pkg::TYPE_P, 64'hFFFF_FFFF_FFFF_FFFF);
    add_insert(32'h8000_0000, spqtc_pkg::TYPE_B, 64'h0);
    add_insert(32'h0000_0000, spqtc_pkg::TYPE_G, "tie_one_");
    add_insert(32'h0000_0000, 8'hFF, "tie_two_");
    add_insert(32'h0000_0000, spqtc_pkg::TYPE_P, "tie_thre");
    add_insert(32'h0000_0100, 8'h00, "one_pt_0");
    add_insert(32'hFFFF_FF00, spqtc_pkg::TYPE_G, "neg_one_");
    repeat (7) add_remove();
    add_remove();
    add_remove();
    add_drain_marker();

    seg_idx = 0;
    while (items_total < 430) begin
      if (seg_idx == 1) mode = SEG_FILL;
      else if (seg_idx == 3) mode = SEG_DRAIN;
      else mode = seg_mode_t'($urandom_range(0, 3));
      case (mode)
        SEG_FILL: begin
          while (gen_fill < QUEUE_DEPTH) add_random_insert();
          repeat ($urandom_range(1, 3)) add_random_insert();   // overflow
        end
        SEG_DRAIN: begin
          while (gen_fill > 0) add_remove();
          repeat ($urandom_range(1, 2)) add_remove();          // empty remove
        end
        default: begin
          pct = (mode == SEG_MOSTLY_IN) ? 75 : 50;
          repeat ($urandom_range(20, 60)) begin
            if ($urandom_range(0, 99) < pct) add_random_insert();
            else add_remove();
          end
        end
      endcase
      if (seg_idx == 1) add_drain_marker();
      seg_idx++;
    end
    quiet_from = items_total - TAIL_QUIET;

    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (items_taken < items_total || result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("sorted_priority_queue_type_counts regression: pass");
    else
      $display("sorted_priority_queue_type_counts regression: fail");
    $finish;
  end

  // Driver
  int sender_gap = 0;

  always @(negedge clk) begin : drive_proc
    logic busy_n;
    if (!rst_n) begin
      drv_valid <= 1'b0;
      sender_gap = 0;
    end else begin
      busy_n = drv_valid && !in_fire;
      if (in_fire && items_taken < quiet_from && $urandom_range(0, 5) == 0)
        sender_gap = $urandom_range(1, 7);
      if (!busy_n) begin
        if (sender_gap > 0) begin
          sender_gap--;
        end else begin
          if (stim_q.size() > 0 && stim_q[0].drain && result_q.size() == 0)
            void'(stim_q.pop_front());
          if (stim_q.size() > 0 && !stim_q[0].drain) begin
            offered = stim_q.pop_front();
            busy_n = 1'b1;
          end
        end
      end
      drv_valid <= busy_n;
    end
  end

  // Sink ready: random bursts, one long hold so the block backs up
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      rcv_ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD_LEN - 1;
      rcv_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rcv_ready <= 1'b0;
    end else if (items_taken < quiet_from && $urandom_range(0, 4) == 0) begin
      hold_left = $urandom_range(0, 6);
      rcv_ready <= 1'b0;
    end else begin
      rcv_ready <= 1'b1;
    end
  end

  // Prediction and checking at the rising edge
  always @(posedge clk) begin : score_proc
    result_t want;
    result_t got;
    bit      bad;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_chan.valid && in_chan.ready;

      if (out_chan.valid && out_chan.ready) begin
        results_seen++;
        got.removed_valid = out_chan.removed_valid;
        got.removed_value = out_chan.removed_value;
        got.removed_type  = out_chan.removed_type;
        got.removed_code  = out_chan.removed_code;
        got.overflow      = out_chan.overflow;
        got.occupancy     = out_chan.occupancy;
        got.count_p       = out_chan.count_p;
        got.count_b       = out_chan.count_b;
        got.count_g       = out_chan.count_g;
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result word with nothing expected: %h", $realtime, got);
        end else begin
          want = result_q.pop_front();
          bad = (got.removed_valid !== want.removed_valid) ||
                (got.removed_value !== want.removed_value) ||
                (got.removed_type  !== want.removed_type)  ||
                (got.removed_code  !== want.removed_code)  ||
                (got.overflow      !== want.overflow)      ||
                (got.occupancy     !== want.occupancy)     ||
                (got.count_p       !== want.count_p)       ||
                (got.count_b       !== want.count_b)       ||
                (got.count_g       !== want.count_g);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch on result %0d", $realtime, results_seen);
              $display("  exp rv=%0d val=%h type=%h code=%h ovf=%0d occ=%0d p=%0d b=%0d g=%0d",
                       want.removed_valid, want.removed_value, want.removed_type,
                       want.removed_code, want.overflow, want.occupancy,
                       want.count_p, want.count_b, want.count_g);
              $display("  got rv=%0d val=%h type=%h code=%h ovf=%0d occ=%0d p=%0d b=%0d g=%0d",
                       got.removed_valid, got.removed_value, got.removed_type,
                       got.removed_code, got.overflow, got.occupancy,
                       got.count_p, got.count_b, got.count_g);
            end
          end
        end
      end

      if (in_chan.valid && in_chan.ready) begin
        result_q.push_back(predict_queue_step(offered));
        items_taken++;
      end
    end
  end

  // Watchdog: cycles in which no word moves on either channel
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("sorted_priority_queue_type_counts regression: fail");
        $finish;
      end
    end
  end

endmodule
